// ----- design/aes_pkg.sv -----
// ----------------------------------------------------------------------------
// AES-128 package
// Shared constants, types and GF(2^8) helper functions for the AES-128 core.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int RoundCount = 10;
  localparam int SchedWords = 4 * (RoundCount + 1);
  localparam int WordAw = $clog2(SchedWords);
  localparam int RoundW = $clog2(RoundCount + 1);

  localparam logic [1:0] RegKeyHigh = 2'd0;
  localparam logic [1:0] RegKeyLow = 2'd1;

  localparam logic [7:0] GfPoly = 8'h1b;
  localparam logic [7:0] RconFirst = 8'h01;

  typedef logic [127:0] block_t;
  typedef logic [31:0] word_t;

  typedef struct packed {
    logic load;
    logic dec;
    logic first;
    logic last;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic sched_we;
    logic sched_first;
    logic [WordAw-1:0] sched_addr;
  } ks_cmd_t;

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? GfPoly : 8'h00);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[x];
  endfunction

endpackage

// ----- design/aes_if.sv -----
// ----------------------------------------------------------------------------
// AES stream channels
// Valid/ready channel interfaces for blocks, results and key writes.
// ----------------------------------------------------------------------------
interface aes_in_if;
  logic valid;
  logic ready;
  logic func;
  logic [63:0] block_high;
  logic [63:0] block_low;
  modport source(output valid, func, block_high, block_low, input ready);
  modport sink(input valid, func, block_high, block_low, output ready);
endinterface

interface aes_out_if;
  logic valid;
  logic ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source(output valid, result_high, result_low, input ready);
  modport sink(input valid, result_high, result_low, output ready);
endinterface

interface aes_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [63:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- design/aes128_block_cipher.sv -----
// ----------------------------------------------------------------------------
// AES-128 block cipher
// ECB AES-128 encrypt/decrypt core with an on-chip round key store.
// ----------------------------------------------------------------------------
//  channel | role   | beat
//  in_ch   | sink   | func, block_high, block_low
//  out_ch  | source | result_high, result_low
//  cfg_ch  | sink   | index, data (0 = key_high, 1 = key_low)
//
// A block passes through the accept cycle, eleven rounds of four round key
// word reads from the key store's single read port plus a step in the shared
// round unit, and the result state.
// After reset or a key write the schedule is expanded before the next block
// is accepted. A stalled result holds and blocks new input.
module aes128_block_cipher (
  input logic clk,
  input logic rst,
  aes_in_if.sink in_ch,
  aes_out_if.source out_ch,
  aes_cfg_if.sink cfg_ch
);
  import aes_pkg::*;

  dp_cmd_t dp_cmd;
  ks_cmd_t ks_cmd;
  logic [WordAw-1:0] rd_addr;
  logic cfg_we;
  logic [127:0] result;

  assign cfg_ch.ready = 1'b1;
  assign cfg_we = cfg_ch.valid;

  aes_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_ch.valid),
    .in_func(in_ch.func),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .key_written(cfg_we && (cfg_ch.index == RegKeyHigh || cfg_ch.index == RegKeyLow)),
    .dp_cmd(dp_cmd),
    .ks_cmd(ks_cmd),
    .rd_base(rd_addr)
  );

  aes_dp u_dp (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_ch.index),
    .cfg_data(cfg_ch.data),
    .in_block({in_ch.block_high, in_ch.block_low}),
    .dp_cmd(dp_cmd),
    .ks_cmd(ks_cmd),
    .rd_addr(rd_addr),
    .result(result)
  );

  assign out_ch.result_high = result[127:64];
  assign out_ch.result_low = result[63:0];

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("input accepted while result pending");
  a_result_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !out_ch.valid) else $error("result too early");
  a_no_expand_during_block: assert property (@(posedge clk) disable iff (rst)
    ks_cmd.sched_we |-> !out_ch.valid) else $error("schedule write during result");
endmodule

// ----- design/aes_ram.sv -----
// ----------------------------------------------------------------------------
// AES generic RAM
// Single-port write, single-port read memory with registered read data.
// ----------------------------------------------------------------------------
module aes_ram #(
  parameter int Width = 32,
  parameter int Depth = 44
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- design/aes_ctrl.sv -----
// ----------------------------------------------------------------------------
// AES controller
// Sequences key expansion, round key fetches and the eleven cipher rounds.
// ----------------------------------------------------------------------------
module aes_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_func,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  input  logic                      key_written,
  output aes_pkg::dp_cmd_t          dp_cmd,
  output aes_pkg::ks_cmd_t          ks_cmd,
  output logic [aes_pkg::WordAw-1:0] rd_base
);
  import aes_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXP   = 5'b00010,
    S_FETCH = 5'b00100,
    S_RUN   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic sched_ok;
  logic dec;
  logic [WordAw-1:0] widx;
  logic [1:0] col;
  logic [RoundW-1:0] rnd;
  logic [RoundW-1:0] key_rnd;
  logic accept;

  assign in_ready = (state == S_IDLE) && sched_ok;
  assign accept = in_valid && in_ready;
  assign out_valid = (state == S_DONE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (!sched_ok) state_next = S_EXP;
        else if (in_valid) state_next = S_FETCH;
      end
      S_EXP: if (widx == WordAw'(SchedWords - 1)) state_next = S_IDLE;
      S_FETCH: if (col == 2'd3) state_next = S_RUN;
      S_RUN: state_next = (rnd == RoundW'(RoundCount)) ? S_DONE : S_FETCH;
      S_DONE: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Round key words are read one per cycle; the datapath gathers a full
  // round key over four reads, then applies the round.
  always_comb begin
    key_rnd = dec ? RoundW'(RoundCount - 32'(rnd)) : rnd;
  end

  assign rd_base = WordAw'({key_rnd, 2'b00}) + WordAw'(col);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sched_ok <= 1'b0;
      widx <= '0;
      col <= '0;
      rnd <= '0;
      dec <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          widx <= '0;
          col <= '0;
          rnd <= '0;
          if (accept) dec <= in_func;
        end
        S_EXP: begin
          widx <= widx + 1'b1;
          if (widx == WordAw'(SchedWords - 1)) sched_ok <= 1'b1;
        end
        S_FETCH: col <= col + 1'b1;
        S_RUN: rnd <= rnd + 1'b1;
        default: ;
      endcase
      if (key_written) sched_ok <= 1'b0;
    end
  end

  // The round is applied in the cycle in which the last word's read data arrives.
  always_comb begin
    dp_cmd.load = accept;
    dp_cmd.dec = dec;
    dp_cmd.first = (rnd == '0);
    dp_cmd.last = (rnd == RoundW'(RoundCount));
    dp_cmd.step = (state == S_RUN);
    ks_cmd.sched_we = (state == S_EXP);
    ks_cmd.sched_first = (widx < WordAw'(4));
    ks_cmd.sched_addr = widx;
  end
endmodule

// ----- design/aes_dp.sv -----
// ----------------------------------------------------------------------------
// AES datapath
// Key schedule generator, round key store and the shared round unit.
// ----------------------------------------------------------------------------
module aes_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [63:0]                cfg_data,
  input  logic [127:0]               in_block,
  input  aes_pkg::dp_cmd_t           dp_cmd,
  input  aes_pkg::ks_cmd_t           ks_cmd,
  input  logic [aes_pkg::WordAw-1:0] rd_addr,
  output logic [127:0]               result
);
  import aes_pkg::*;

  logic [63:0] key_high, key_low;
  word_t w [4];
  word_t gen_word;
  logic [7:0] rcon;
  word_t rk_word;
  word_t rk [3];
  word_t kw [4];
  block_t state;
  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] m [16];
  block_t round_out;
  word_t rot;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
    end else if (cfg_we) begin
      if (cfg_index == RegKeyHigh) key_high <= cfg_data;
      if (cfg_index == RegKeyLow) key_low <= cfg_data;
    end
  end

  // The last four generated words sit in a shift line.
  always_comb begin
    rot = {w[3][23:0], w[3][31:24]};
    if (ks_cmd.sched_first) begin
      case (ks_cmd.sched_addr[1:0])
        2'd0: gen_word = key_high[63:32];
        2'd1: gen_word = key_high[31:0];
        2'd2: gen_word = key_low[63:32];
        default: gen_word = key_low[31:0];
      endcase
    end else if (ks_cmd.sched_addr[1:0] == 2'd0) begin
      gen_word = w[0] ^ {sbox(rot[31:24]) ^ rcon, sbox(rot[23:16]),
                         sbox(rot[15:8]), sbox(rot[7:0])};
    end else begin
      gen_word = w[0] ^ w[3];
    end
  end

  always_ff @(posedge clk) begin
    if (ks_cmd.sched_we) begin
      w[0] <= w[1];
      w[1] <= w[2];
      w[2] <= w[3];
      w[3] <= gen_word;
      if (ks_cmd.sched_first) rcon <= RconFirst;
      else if (ks_cmd.sched_addr[1:0] == 2'd0) rcon <= xtime(rcon);
    end
  end

  aes_ram #(.Width(32), .Depth(SchedWords)) u_store (
    .clk(clk),
    .we(ks_cmd.sched_we),
    .waddr(ks_cmd.sched_addr),
    .wdata(gen_word),
    .raddr(rd_addr),
    .rdata(rk_word)
  );

  // Read data arrives in the cycle after the address. The first three words of
  // a round key sit in a shift line; the fourth comes straight from the store.
  always_ff @(posedge clk) begin
    rk[0] <= rk[1];
    rk[1] <= rk[2];
    rk[2] <= rk_word;
  end

  always_comb begin
    kw[0] = rk[0];
    kw[1] = rk[1];
    kw[2] = rk[2];
    kw[3] = rk_word;
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state[127 - 8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (dp_cmd.dec) t[r + 4*((c + r) % 4)] = inv_sbox(s[r + 4*c]);
        else t[r + 4*c] = sbox(s[r + 4*((c + r) % 4)]);
      end
    end
    for (int i = 0; i < 16; i++) begin
      m[i] = t[i] ^ kw[i/4][31 - 8*(i%4) -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, y0, y1, y2, y3;
      if (dp_cmd.dec) begin
        a0 = m[4*c]; a1 = m[4*c+1]; a2 = m[4*c+2]; a3 = m[4*c+3];
      end else begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      end
      x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
      y0 = xtime(x0); y1 = xtime(x1); y2 = xtime(x2); y3 = xtime(x3);
      if (dp_cmd.dec) begin
        // Pre-step: fold 4*(a0^a2) etc., then forward mix gives inverse mix.
        a0 = a0 ^ y0 ^ y2;
        a1 = a1 ^ y1 ^ y3;
        a2 = a2 ^ y0 ^ y2;
        a3 = a3 ^ y1 ^ y3;
        x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
      end
      round_out[127 - 8*(4*c) -: 8]   = x0 ^ x1 ^ a1 ^ a2 ^ a3;
      round_out[127 - 8*(4*c+1) -: 8] = a0 ^ x1 ^ x2 ^ a2 ^ a3;
      round_out[127 - 8*(4*c+2) -: 8] = a0 ^ a1 ^ x2 ^ x3 ^ a3;
      round_out[127 - 8*(4*c+3) -: 8] = x0 ^ a0 ^ a1 ^ a2 ^ x3;
      if (!dp_cmd.dec) begin
        for (int r = 0; r < 4; r++) begin
          round_out[127 - 8*(4*c+r) -: 8] =
            round_out[127 - 8*(4*c+r) -: 8] ^ kw[c][31 - 8*r -: 8];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      state <= in_block;
    end else if (dp_cmd.step) begin
      if (dp_cmd.first) begin
        state <= state ^ {kw[0], kw[1], kw[2], kw[3]};
      end else if (dp_cmd.last) begin
        for (int i = 0; i < 16; i++) begin
          state[127 - 8*i -: 8] <= dp_cmd.dec ? m[i] :
                                   (t[i] ^ kw[i/4][31 - 8*(i%4) -: 8]);
        end
      end else begin
        state <= round_out;
      end
    end
  end

  assign result = state;
endmodule

// ----- bench/aes128_block_cipher_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block cipher testbench
// Drives blocks in random bursts against a randomly stalled result channel,
// rewrites the key between phases while the core is idle, and compares every
// result with an AES-128 encryption or inverse cipher computed in the bench.
// ----------------------------------------------------------------------------
module aes128_block_cipher_tb;
  import aes_pkg::*;

  typedef enum logic {OP_ENCRYPT = 1'b0, OP_DECRYPT = 1'b1} cipher_op_e;

  localparam logic [1:0] RegSpareA = 2'd2;
  localparam logic [1:0] RegSpareB = 2'd3;
  localparam int IdleHold = 60;
  localparam int StallLimit = 3000;

  logic clk;
  logic rst;

  aes_in_if in_ch();
  aes_out_if out_ch();
  aes_cfg_if cfg_ch();

  aes128_block_cipher dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  logic [7:0] fwd_tab [256];
  logic [7:0] inv_tab [256];
  logic [63:0] cur_key_high;
  logic [63:0] cur_key_low;
  word_t round_keys [SchedWords];
  block_t expected_blocks [$];
  int error_count;
  int burst_left;
  int idle_cycles;
  bit stall_free;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] gf_dbl(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_prod(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc ^= a;
      a = gf_dbl(a);
    end
    return acc;
  endfunction

  task automatic build_sbox_tables();
    logic [7:0] y;
    logic [7:0] a;
    for (int x = 0; x < 256; x++) begin
      y = 8'h00;
      for (int c = 1; c < 256; c++) begin
        if (x != 0 && gf_prod(x[7:0], c[7:0]) == 8'h01) y = c[7:0];
      end
      a = y ^ {y[6:0], y[7]} ^ {y[5:0], y[7:6]} ^ {y[4:0], y[7:5]} ^ {y[3:0], y[7:4]} ^ 8'h63;
      fwd_tab[x] = a;
      inv_tab[a] = x[7:0];
    end
  endtask

  task automatic expand_round_keys();
    word_t t;
    logic [7:0] rc;
    rc = 8'h01;
    round_keys[0] = cur_key_high[63:32];
    round_keys[1] = cur_key_high[31:0];
    round_keys[2] = cur_key_low[63:32];
    round_keys[3] = cur_key_low[31:0];
    for (int i = 4; i < SchedWords; i++) begin
      t = round_keys[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {fwd_tab[t[31:24]], fwd_tab[t[23:16]], fwd_tab[t[15:8]], fwd_tab[t[7:0]]}
            ^ {rc, 24'h0};
        rc = gf_dbl(rc);
      end
      round_keys[i] = round_keys[i-4] ^ t;
    end
  endtask

  function automatic block_t add_round_key(input block_t s, input int rnd);
    for (int c = 0; c < 4; c++) s[127-32*c -: 32] ^= round_keys[4*rnd+c];
    return s;
  endfunction

  function automatic block_t sub_shift(input block_t s, input bit inverse);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inverse)
          t[127-8*(r+4*((c+r)%4)) -: 8] = inv_tab[s[127-8*(r+4*c) -: 8]];
        else
          t[127-8*(r+4*c) -: 8] = fwd_tab[s[127-8*(r+4*((c+r)%4)) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic block_t mix_columns(input block_t s, input bit inverse);
    logic [7:0] m [4];
    logic [7:0] acc;
    block_t t;
    if (inverse) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else m = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++) acc ^= gf_prod(m[(k-r+4)%4], s[127-8*(4*c+k) -: 8]);
        t[127-8*(4*c+r) -: 8] = acc;
      end
    end
    return t;
  endfunction

  function automatic block_t cipher_block(input cipher_op_e op, input block_t s);
    if (op == OP_ENCRYPT) begin
      s = add_round_key(s, 0);
      for (int rnd = 1; rnd <= RoundCount; rnd++) begin
        s = sub_shift(s, 1'b0);
        if (rnd != RoundCount) s = mix_columns(s, 1'b0);
        s = add_round_key(s, rnd);
      end
    end else begin
      s = add_round_key(s, RoundCount);
      for (int rnd = RoundCount - 1; rnd >= 0; rnd--) begin
        s = sub_shift(s, 1'b1);
        s = add_round_key(s, rnd);
        if (rnd != 0) s = mix_columns(s, 1'b1);
      end
    end
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $realtime);
    error_count++;
  endtask

  task automatic send_block(input cipher_op_e op, input logic [63:0] hi, input logic [63:0] lo);
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.func = op;
    in_ch.block_high = hi;
    in_ch.block_low = lo;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    expected_blocks.push_back(cipher_block(op, {hi, lo}));
    @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
    in_ch.valid = 1'b0;
    while (expected_blocks.size() > 0) @(negedge clk);
    repeat (IdleHold) @(negedge clk);
    cfg_ch.index = idx;
    cfg_ch.data = value;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    if (idx == RegKeyHigh) cur_key_high = value;
    if (idx == RegKeyLow) cur_key_low = value;
    expand_round_keys();
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_reset_key();
    send_block(OP_ENCRYPT, 64'h0, 64'h0);
    send_block(OP_DECRYPT, 64'h0, 64'h0);
    send_block(OP_ENCRYPT, '1, '1);
  endtask

  task automatic test_standard_vector();
    write_register(RegKeyHigh, 64'h0001020304050607);
    write_register(RegKeyLow, 64'h08090a0b0c0d0e0f);
    send_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(OP_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    send_block(OP_DECRYPT, '1, 64'h0);
    send_block(OP_ENCRYPT, 64'h8000000000000000, 64'h1);
  endtask

  task automatic test_extreme_keys();
    write_register(RegKeyHigh, '1);
    write_register(RegKeyLow, '1);
    send_block(OP_ENCRYPT, '1, '1);
    send_block(OP_DECRYPT, 64'h0, 64'h0);
    write_register(RegKeyLow, 64'h0);
    send_block(OP_ENCRYPT, 64'h0, '1);
    write_register(RegKeyHigh, 64'h0);
    send_block(OP_DECRYPT, '1, '1);
    send_block(OP_ENCRYPT, 64'h0, 64'h0);
  endtask

  task automatic test_ignored_index();
    write_register(RegSpareA, '1);
    send_block(OP_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
    write_register(RegSpareB, rand64());
    send_block(OP_DECRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
  endtask

  task automatic test_random_traffic();
    logic [63:0] hi;
    logic [63:0] lo;
    for (int phase = 0; phase < 9; phase++) begin
      case ($urandom_range(0, 3))
        0: write_register(RegKeyHigh, rand64());
        1: write_register(RegKeyLow, rand64());
        default: begin
          write_register(RegKeyHigh, rand64());
          write_register(RegKeyLow, rand64());
        end
      endcase
      for (int n = 0; n < 148; n++) begin
        hi = rand64();
        lo = rand64();
        if ($urandom_range(0, 15) == 0) hi = $urandom_range(0, 1) ? '1 : '0;
        if ($urandom_range(0, 15) == 0) lo = $urandom_range(0, 1) ? '1 : '0;
        send_block(cipher_op_e'($urandom_range(0, 1)), hi, lo);
      end
    end
  endtask

  always @(posedge clk) begin
    block_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_blocks.size() == 0) begin
        report_mismatch("unexpected result_high", 64'h0, out_ch.result_high);
      end else begin
        want = expected_blocks.pop_front();
        if (out_ch.result_high !== want[127:64])
          report_mismatch("result_high", want[127:64], out_ch.result_high);
        if (out_ch.result_low !== want[63:0])
          report_mismatch("result_low", want[63:0], out_ch.result_low);
      end
    end
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) stall_free = ~stall_free;
    out_ch.ready <= stall_free ? 1'b1 : ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.func = OP_ENCRYPT;
    in_ch.block_high = '0;
    in_ch.block_low = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = RegKeyHigh;
    cfg_ch.data = '0;
    cur_key_high = '0;
    cur_key_low = '0;
    error_count = 0;
    burst_left = 0;
    idle_cycles = 0;
    stall_free = 1'b0;
    build_sbox_tables();
    expand_round_keys();
    repeat (8) @(negedge clk);
    rst = 1'b0;
    test_reset_key();
    test_standard_vector();
    test_extreme_keys();
    test_ignored_index();
    test_random_traffic();
    in_ch.valid = 1'b0;
    while (expected_blocks.size() > 0) @(negedge clk);
    repeat (IdleHold) @(negedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
design/aes_pkg.sv
design/aes_if.sv
design/aes_ram.sv
design/aes_ctrl.sv
design/aes_dp.sv
design/aes128_block_cipher.sv
bench/aes128_block_cipher_tb.sv
